>>> rtl/slt_pkg.sv
`timescale 1ns / 1ps
// slt_pkg: request codes, default capacity and the command/status structs
// shared by the list controller and datapath; no dependencies
package slt_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    typedef struct packed {
        logic load;
        logic append;
        logic scan;
        logic start_shift;
        logic shift;
        logic dec;
        logic read_issue;
        logic finish;
        logic ok;
    } slt_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       empty;
        logic       pos_ok;
        logic       match;
        logic       scan_done;
        logic       out_free;
    } slt_status_t;

endpackage

>>> rtl/slt_datapath.sv
`timescale 1ns / 1ps
// slt_datapath: entry memory, fill count, scan/shift pointers and output beat register
// depends on slt_pkg
module slt_datapath
    import slt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CW = $clog2(CAPACITY + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  slt_cmd_t           cmd,
    output slt_status_t        status,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] value,
    input  logic [4:0]         position,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               ok,
    output logic signed [31:0] read_value,
    output logic [CW-1:0]      count,
    output logic               empty_res,
    output logic               full_res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (CW > 5) ? CW : 5;

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rd_data_reg;

    logic [1:0]    req_reg;
    logic [31:0]   val_reg;
    logic [4:0]    pos_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] rd_idx_reg;
    logic          rd_vld_reg, rd_vld_next;

    logic          out_vld_reg;
    logic          ok_reg;
    logic [31:0]   rv_reg;
    logic [CW-1:0] cnt_out_reg;
    logic          empty_reg, full_reg;

    logic          idx_live, issue, rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr, pos_addr;
    logic [31:0]   wr_data;
    logic [PW-1:0] pos_ext, cnt_ext;

    assign pos_ext  = PW'(pos_reg);
    assign cnt_ext  = PW'(cnt_reg);
    assign pos_addr = AW'(pos_ext);
    assign idx_live = idx_reg < cnt_reg;
    assign issue    = (cmd.scan | cmd.shift) & idx_live;
    assign rd_en    = issue | cmd.read_issue;
    assign rd_addr  = cmd.read_issue ? pos_addr : idx_reg[AW-1:0];
    assign wr_en    = cmd.append | (cmd.shift & rd_vld_reg);
    assign wr_addr  = cmd.append ? cnt_reg[AW-1:0] : rd_idx_reg - AW'(1);
    assign wr_data  = cmd.append ? val_reg : rd_data_reg;

    assign status.req       = req_reg;
    assign status.full      = cnt_reg == CW'(CAPACITY);
    assign status.empty     = cnt_reg == '0;
    assign status.pos_ok    = pos_ext < cnt_ext;
    assign status.match     = rd_vld_reg & (rd_data_reg == val_reg);
    assign status.scan_done = !idx_live & !rd_vld_reg;
    assign status.out_free  = !out_vld_reg | !out_stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        rd_vld_next = rd_vld_reg;
        if (cmd.append)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        if (cmd.load)
        begin
            idx_next    = '0;
            rd_vld_next = 1'b0;
        end
        else if (cmd.start_shift)
        begin
            idx_next    = CW'(rd_idx_reg) + CW'(1);
            rd_vld_next = 1'b0;
        end
        else if (cmd.scan | cmd.shift)
        begin
            rd_vld_next = issue;
            if (issue)
            begin
                idx_next = idx_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_vld_next;
            if (cmd.finish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            val_reg <= value;
            pos_reg <= position;
        end
        if (issue)
        begin
            rd_idx_reg <= idx_reg[AW-1:0];
        end
        if (cmd.finish)
        begin
            ok_reg      <= cmd.ok;
            rv_reg      <= (cmd.ok && req_reg == REQ_READ) ? rd_data_reg : '0;
            cnt_out_reg <= cnt_reg;
            empty_reg   <= cnt_reg == '0;
            full_reg    <= cnt_reg == CW'(CAPACITY);
        end
    end

    assign out_valid  = out_vld_reg;
    assign ok         = ok_reg;
    assign read_value = rv_reg;
    assign count      = cnt_out_reg;
    assign empty_res  = empty_reg;
    assign full_res   = full_reg;

endmodule

>>> rtl/slt_ctrl.sv
`timescale 1ns / 1ps
// slt_ctrl: request sequencer for append, search-and-shift removal and read
// depends on slt_pkg
module slt_ctrl
    import slt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  slt_status_t status,
    output slt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        IDLE,
        DECODE,
        SRCH,
        SHIFT,
        FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ok_reg, ok_next;

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        cmd        = '0;
        cmd.ok     = ok_reg;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = DECODE;
                end
            end
            DECODE:
            begin
                ok_next    = 1'b0;
                state_next = FINISH;
                case (status.req)
                    REQ_APPEND:
                    begin
                        if (!status.full)
                        begin
                            cmd.append = 1'b1;
                            ok_next    = 1'b1;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!status.empty)
                        begin
                            state_next = SRCH;
                        end
                    end
                    REQ_READ:
                    begin
                        if (status.pos_ok)
                        begin
                            cmd.read_issue = 1'b1;
                            ok_next        = 1'b1;
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            SRCH:
            begin
                if (status.match)
                begin
                    cmd.start_shift = 1'b1;
                    state_next      = SHIFT;
                end
                else if (status.scan_done)
                begin
                    ok_next    = 1'b0;
                    state_next = FINISH;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            SHIFT:
            begin
                if (status.scan_done)
                begin
                    cmd.dec    = 1'b1;
                    ok_next    = 1'b1;
                    state_next = FINISH;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

    assign in_stall = state_reg != IDLE;

endmodule

>>> rtl/sequential_list_table.sv
`timescale 1ns / 1ps
// sequential_list_table: ordered list of signed 32-bit entries with append,
// remove-first-match and indexed read; depends on slt_pkg, slt_ctrl, slt_datapath
//
//   channel   direction  handshake             payload
//   request   in         in_valid / in_stall   req_type, value, position
//   result    out        out_valid / out_stall ok, read_value, count, empty_res, full_res
//
// append, read and removal from an empty list go from decode straight to the result
// register; a removal scans entries up to the first match, then shifts each later entry
// down by one and decrements the count; a miss scans every entry and changes nothing
// reset clears the fill count and control state; entry contents stay undefined
// a result beat waits in the output register under out_stall; the next request
// is accepted meanwhile and holds its result until the register frees
module sequential_list_table
    import slt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CW = $clog2(CAPACITY + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] value,
    input  logic [4:0]         position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic signed [31:0] read_value,
    output logic [CW-1:0]      count,
    output logic               empty_res,
    output logic               full_res
);

    slt_cmd_t    cmd;
    slt_status_t status;

    slt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    slt_datapath #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .req_type   (req_type),
        .value      (value),
        .position   (position),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .ok         (ok),
        .read_value (read_value),
        .count      (count),
        .empty_res  (empty_res),
        .full_res   (full_res)
    );

endmodule
